// ----- hdl/wbps_pkg.sv -----
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types and constants of the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
package wbps_pkg;

	// fixed pattern storage of the register map
	localparam int PATTERN_SLOTS = 16;
	localparam int LEN_W         = 5;
	localparam int BYTE_W        = 8;

	// configuration port
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 64;

	// stream payloads
	localparam int IN_TDATA_W   = 8;
	localparam int ADDR_W       = 64;
	localparam int OFFSET_W     = 32;
	localparam int OUT_FIELDS_W = 1 + ADDR_W;
	localparam int OUT_TDATA_W  = 72;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PATTERN_LOW  = 3'd0,
		REG_PATTERN_HIGH = 3'd1,
		REG_WILDCARD     = 3'd2,
		REG_LENGTH       = 3'd3,
		REG_SCAN_BASE    = 3'd4,
		REG_OFFSET       = 3'd5
	} cfg_reg_t;

	// what one window cell compares against
	typedef struct packed {
		logic              en;
		logic              wild;
		logic [BYTE_W-1:0] pat;
	} cell_ctl_t;

endpackage

// ----- hdl/wbps_cell.sv -----
// ----------------------------------------------------------------------------
// wbps_cell
// One window cell: holds a byte, passes it on, compares it with its pattern byte.
// ----------------------------------------------------------------------------
module wbps_cell (
	input  logic                      clk,
	input  logic                      shift_en,
	input  logic [wbps_pkg::BYTE_W-1:0] in_byte,
	input  wbps_pkg::cell_ctl_t       ctl,
	output logic [wbps_pkg::BYTE_W-1:0] out_byte,
	output logic                      match
);
	import wbps_pkg::*;

	logic [BYTE_W-1:0] byte_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			byte_q <= in_byte;
		end
	end

	assign out_byte = byte_q;

	// cells beyond the active length never block a hit
	assign match = !ctl.en || ctl.wild || (byte_q == ctl.pat);

endmodule

// ----- hdl/wildcard_byte_pattern_scan.sv -----
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scan
// Searches a byte stream for the first place a wildcarded pattern matches.
// ----------------------------------------------------------------------------
// Bytes of a region arrive on the s_axis channel in address order, one request
// per byte, with tlast on the region's final byte. Each accepted byte enters a
// row of window cells; every cell compares its byte with the pattern byte for
// its place, so while s_axis_tready is high one byte is taken every cycle,
// with no gaps between regions. The first hit is latched. For the byte
// carrying tlast one result goes out on m_axis: the found flag and base +
// match position + signed offset (zero when nothing matched). The window
// compare for that byte is registered in the verdict register, and the
// address add is then registered in the output register.
// A stalled m_axis receiver does not hold up input at once: one result waits
// in the output register and one more behind it; only a third region end
// waiting in the compare stage drops s_axis_tready.
// Reset empties the pipeline, clears the byte count and match latch, and sets
// the registers to their defaults (pattern length one, all else zero).
// The user must write registers through the cfg port only while no region is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scan #(
	parameter int MAX_PATTERN_BYTES = 16,
	parameter int POSITION_BITS     = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [wbps_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [wbps_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [wbps_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [7:0] data_byte
	input  logic                               s_axis_tlast,  // last_byte
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [wbps_pkg::OUT_TDATA_W-1:0]   m_axis_tdata   // [0] found, [64:1] match_address
);
	import wbps_pkg::*;

	localparam logic [POSITION_BITS-1:0] COUNT_MAX = '1;

	// configuration registers
	logic [63:0]         pat_lo_q;
	logic [63:0]         pat_hi_q;
	logic [15:0]         wild_q;
	logic [LEN_W-1:0]    len_q;
	logic [ADDR_W-1:0]   base_q;
	logic [OFFSET_W-1:0] offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q <= '0;
			pat_hi_q <= '0;
			wild_q   <= '0;
			len_q    <= LEN_W'(1);
			base_q   <= '0;
			offset_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_PATTERN_LOW:  pat_lo_q <= cfg_wdata;
				REG_PATTERN_HIGH: pat_hi_q <= cfg_wdata;
				REG_WILDCARD:     wild_q   <= cfg_wdata[15:0];
				REG_LENGTH:       len_q    <= cfg_wdata[LEN_W-1:0];
				REG_SCAN_BASE:    base_q   <= cfg_wdata;
				REG_OFFSET:       offset_q <= cfg_wdata[OFFSET_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// active length, zero taken as one and clamped to the window
	logic [LEN_W-1:0] alen;

	always_comb begin
		if (len_q == '0) begin
			alen = LEN_W'(1);
		end else if (len_q > LEN_W'(MAX_PATTERN_BYTES)) begin
			alen = LEN_W'(MAX_PATTERN_BYTES);
		end else begin
			alen = len_q;
		end
	end

	logic [POSITION_BITS-1:0] alen_ext;
	assign alen_ext = {{(POSITION_BITS-LEN_W){1'b0}}, alen};

	logic [PATTERN_SLOTS-1:0][BYTE_W-1:0] pat_all;
	assign pat_all = {pat_hi_q, pat_lo_q};

	// handshake and stage control
	logic accept;
	logic valid_s1, last_s1;
	logic s1_adv, s1_fire;
	logic rv_s2, s2_free;
	logic m_tvalid_q, out_free;

	assign out_free      = !m_tvalid_q || m_axis_tready;
	assign s2_free       = !rv_s2 || out_free;
	assign s1_adv        = !(valid_s1 && last_s1) || s2_free;
	assign s1_fire       = valid_s1 && s1_adv;
	assign s_axis_tready = s1_adv;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// byte count of the current region, saturating
	logic [POSITION_BITS-1:0] seen_q, seen_next, seen_s1;

	assign seen_next = (seen_q == COUNT_MAX) ? seen_q : seen_q + POSITION_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				seen_q <= s_axis_tlast ? '0 : seen_next;
			end
			if (s1_adv) begin
				valid_s1 <= s_axis_tvalid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1 <= s_axis_tlast;
			seen_s1 <= seen_next;
		end
	end

	// window cells, cell 0 holds the newest byte
	logic [MAX_PATTERN_BYTES-1:0][BYTE_W-1:0] chain;
	logic [MAX_PATTERN_BYTES-1:0]             cell_match;

	assign chain[0] = s_axis_tdata;

	for (genvar j = 0; j < MAX_PATTERN_BYTES; j++) begin : g_cell
		logic [LEN_W-1:0] pidx;
		cell_ctl_t        ctl;

		// the oldest byte in use lines up with pattern byte 0
		assign pidx     = alen - LEN_W'(1) - LEN_W'(j);
		assign ctl.en   = LEN_W'(j) < alen;
		assign ctl.wild = wild_q[pidx[3:0]];
		assign ctl.pat  = pat_all[pidx[3:0]];

		if (j < MAX_PATTERN_BYTES - 1) begin : g_link
			wbps_cell u_cell (
				.clk      (clk),
				.shift_en (accept),
				.in_byte  (chain[j]),
				.ctl      (ctl),
				.out_byte (chain[j+1]),
				.match    (cell_match[j])
			);
		end else begin : g_end
			wbps_cell u_cell (
				.clk      (clk),
				.shift_en (accept),
				.in_byte  (chain[j]),
				.ctl      (ctl),
				.out_byte (),
				.match    (cell_match[j])
			);
		end
	end

	// first match latch
	logic                     latched_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic                     hit;
	logic [POSITION_BITS-1:0] hit_pos;

	assign hit     = !latched_q && (seen_s1 >= alen_ext) && (&cell_match);
	assign hit_pos = seen_s1 - alen_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latched_q <= 1'b0;
			pos_q     <= '0;
		end else if (s1_fire) begin
			if (last_s1) begin
				latched_q <= 1'b0;
				pos_q     <= '0;
			end else if (hit) begin
				latched_q <= 1'b1;
				pos_q     <= hit_pos;
			end
		end
	end

	// verdict of a finished region
	logic                     found_s2;
	logic [POSITION_BITS-1:0] pos_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s2 <= 1'b0;
		end else if (s2_free) begin
			rv_s2 <= s1_fire && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && last_s1) begin
			found_s2 <= latched_q || hit;
			pos_s2   <= latched_q ? pos_q : hit_pos;
		end
	end

	// output register with the address sum
	logic              found_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] addr_sum;

	assign addr_sum = base_q
		+ {{(ADDR_W-POSITION_BITS){1'b0}}, pos_s2}
		+ {{(ADDR_W-OFFSET_W){offset_q[OFFSET_W-1]}}, offset_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_free) begin
			m_tvalid_q <= rv_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && rv_s2) begin
			found_q <= found_s2;
			addr_q  <= found_s2 ? addr_sum : '0;
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}}, addr_q, found_q};

endmodule
